// File: rtl/pxt_pkg.sv
// Shared types, codes and default constants of the persistent xor trie stack.
package pxt_pkg;

	localparam int KEY_BITS_DEF  = 19;
	localparam int MAX_DEPTH_DEF = 1024;
	localparam int OP_W          = 3;
	localparam int VALUE_W       = 19;
	localparam int POS_W         = 11;
	localparam int ANSWER_W      = 19;
	localparam int STATUS_W      = 2;

	typedef enum logic [OP_W-1:0] {
		OP_PUSH  = 3'd0,
		OP_POP   = 3'd1,
		OP_MASK  = 3'd2,
		OP_MAX   = 3'd3,
		OP_COUNT = 3'd4,
		OP_KTH   = 3'd5
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2,
		ST_RANGE = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECODE,
		S_PUSH_ROOT,
		S_PUSH_WR,
		S_ROOT_CUR,
		S_ROOT_PRE,
		S_Q_A,
		S_Q_B,
		S_Q_C,
		S_DONE
	} state_t;

endpackage

// File: rtl/persistent_xor_trie_stack_query.sv
// Top level of the persistent xor trie stack with range queries.
//
// An item enters on in_valid/in_stall with an operation code, a value and a
// one-based position range. Each item gives exactly one result item with an
// answer and a status on out_valid/out_stall. Items are processed one at a
// time; in_stall is low only while the sequencer is idle.
// A push walks the trie once, reading one node and writing one new node per
// level. A range query reads the two version roots, then makes two reads
// per level on the single node memory read port.
// Errors are reported with a zero answer.
// Each node holds both child pointers and both child counts, so one read per
// version and level settles a query step.
// Reset empties the stack and clears the xor mask; no memory sweep is needed.
// A finished result waits in the output register while out_stall is high,
// and the next item can be taken meanwhile.
module persistent_xor_trie_stack_query #(
	parameter int KEY_BITS  = pxt_pkg::KEY_BITS_DEF,
	parameter int MAX_DEPTH = pxt_pkg::MAX_DEPTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [pxt_pkg::OP_W-1:0]       operation,
	input  logic [pxt_pkg::VALUE_W-1:0]    value,
	input  logic [pxt_pkg::POS_W-1:0]      left,
	input  logic [pxt_pkg::POS_W-1:0]      right,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [pxt_pkg::ANSWER_W-1:0]   answer,
	output logic [pxt_pkg::STATUS_W-1:0]   status
);

	localparam int NODES = MAX_DEPTH * (KEY_BITS + 1) + 1;
	localparam int NW    = $clog2(NODES);
	localparam int TW    = $clog2(MAX_DEPTH + 1);
	localparam int CW    = TW;
	localparam int LW    = $clog2(KEY_BITS + 1);
	localparam int VW    = (KEY_BITS > pxt_pkg::VALUE_W) ? KEY_BITS : pxt_pkg::VALUE_W;
	localparam int CPW   = ((TW > pxt_pkg::POS_W) ? TW : pxt_pkg::POS_W) + 1;
	localparam int LENW  = pxt_pkg::POS_W + 1;
	localparam int DW    = 2 * NW + 3 * CW;
	localparam logic [NW-1:0] STEP = NW'(KEY_BITS + 1);

	pxt_pkg::state_t state_q, state_d;

	logic [pxt_pkg::OP_W-1:0]     op_q;
	logic [pxt_pkg::VALUE_W-1:0]  val_q;
	logic [pxt_pkg::POS_W-1:0]    left_q, right_q;
	logic [TW-1:0]                top_q;
	logic [NW-1:0]                free_q;
	logic [KEY_BITS-1:0]          mask_q, key_q, msk_sh_q, ans_q;
	logic [pxt_pkg::VALUE_W-1:0]  k_q;
	logic [CW-1:0]                acc_q;
	logic [NW-1:0]                cur_q, pre_q, nn_q;
	logic [DW-1:0]                curd_q;
	logic [LW-1:0]                lvl_q;
	logic [pxt_pkg::ANSWER_W-1:0] res_ans_q, answer_q;
	logic [pxt_pkg::STATUS_W-1:0] res_st_q, status_q;
	logic                         out_valid_q;

	logic          nd_we;
	logic [NW-1:0] nd_waddr, nd_raddr;
	logic [DW-1:0] nd_wdata, nd_rdata;
	logic          rt_we;
	logic [TW-1:0] rt_waddr, rt_raddr;
	logic [NW-1:0] rt_wdata, rt_rdata;

	logic [VW-1:0]       val_x;
	logic                over;
	logic [KEY_BITS-1:0] keyv, bound;
	logic                range_bad, rank_bad, out_free, accept;
	logic [LENW-1:0]     len;

	logic [NW-1:0] od_c0, od_c1, cd_c0, cd_c1, pd_c0, pd_c1;
	logic [CW-1:0] od_n0, od_n1, od_cnt, cd_n0, cd_n1, pd_n0, pd_n1;
	logic          pbit, kb, mb, bb, side, take;
	logic [CW-1:0] diff_m, diff_w, diff_s, acc_n;
	logic [KEY_BITS-1:0] ans_n;
	logic [NW-1:0] old_next, cur_next, pre_next;

	pxt_ram #(.DEPTH(NODES), .AW(NW), .DW(DW)) u_nodes (
		.clk(clk), .we(nd_we), .waddr(nd_waddr), .wdata(nd_wdata),
		.raddr(nd_raddr), .rdata(nd_rdata)
	);

	pxt_ram #(.DEPTH(MAX_DEPTH + 1), .AW(TW), .DW(NW)) u_roots (
		.clk(clk), .we(rt_we), .waddr(rt_waddr), .wdata(rt_wdata),
		.raddr(rt_raddr), .rdata(rt_rdata)
	);

	assign in_stall  = (state_q != pxt_pkg::S_IDLE);
	assign accept    = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign answer    = answer_q;
	assign status    = status_q;
	assign out_free  = !out_valid_q || !out_stall;

	assign val_x     = VW'(val_q);
	assign over      = (val_x >> KEY_BITS) != '0;
	assign keyv      = val_x[KEY_BITS-1:0];
	assign bound     = over ? '1 : keyv;
	assign range_bad = (left_q == '0) || (CPW'(right_q) > CPW'(top_q)) || (left_q > right_q);
	assign len       = LENW'(right_q) - LENW'(left_q) + LENW'(1);
	assign rank_bad  = (val_q == '0) || (32'(val_q) > 32'(len));

	assign {od_c0, od_c1, od_n0, od_n1, od_cnt} = nd_rdata;
	assign {pd_c0, pd_c1, pd_n0, pd_n1}         = nd_rdata[DW-1:CW];
	assign {cd_c0, cd_c1, cd_n0, cd_n1}         = curd_q[DW-1:CW];

	assign pbit     = key_q[KEY_BITS-1];
	assign old_next = pbit ? od_c1 : od_c0;

	assign kb     = key_q[KEY_BITS-1];
	assign bb     = key_q[KEY_BITS-1];
	assign mb     = msk_sh_q[KEY_BITS-1];
	assign diff_m = mb ? (cd_n1 - pd_n1) : (cd_n0 - pd_n0);
	assign diff_w = kb ? (cd_n0 - pd_n0) : (cd_n1 - pd_n1);

	always_comb begin
		take = 1'b0;
		side = mb;
		case (pxt_pkg::op_t'(op_q))
			pxt_pkg::OP_MAX: begin
				take = (diff_w != '0);
				side = take ? !kb : kb;
			end
			pxt_pkg::OP_COUNT: begin
				side = bb ? !mb : mb;
			end
			pxt_pkg::OP_KTH: begin
				take = pxt_pkg::VALUE_W'(diff_m) < k_q;
				side = take ? !mb : mb;
			end
			default: begin
				side = mb;
			end
		endcase
	end

	assign diff_s   = side ? (cd_n1 - pd_n1) : (cd_n0 - pd_n0);
	assign cur_next = side ? cd_c1 : cd_c0;
	assign pre_next = side ? pd_c1 : pd_c0;
	assign ans_n    = KEY_BITS'({ans_q, take});
	assign acc_n    = acc_q + (bb ? diff_m : CW'(0)) + ((lvl_q == LW'(1)) ? diff_s : CW'(0));

	always_comb begin
		state_d = state_q;
		case (state_q)
			pxt_pkg::S_IDLE: begin
				if (accept) begin
					state_d = pxt_pkg::S_DECODE;
				end
			end
			pxt_pkg::S_DECODE: begin
				case (pxt_pkg::op_t'(op_q))
					pxt_pkg::OP_PUSH: begin
						state_d = (top_q == TW'(MAX_DEPTH)) ? pxt_pkg::S_DONE
							: pxt_pkg::S_PUSH_ROOT;
					end
					pxt_pkg::OP_MAX, pxt_pkg::OP_COUNT: begin
						state_d = range_bad ? pxt_pkg::S_DONE : pxt_pkg::S_ROOT_CUR;
					end
					pxt_pkg::OP_KTH: begin
						state_d = (range_bad || rank_bad) ? pxt_pkg::S_DONE
							: pxt_pkg::S_ROOT_CUR;
					end
					default: begin
						state_d = pxt_pkg::S_DONE;
					end
				endcase
			end
			pxt_pkg::S_PUSH_ROOT: state_d = pxt_pkg::S_PUSH_WR;
			pxt_pkg::S_PUSH_WR: begin
				if (lvl_q == '0) begin
					state_d = pxt_pkg::S_DONE;
				end
			end
			pxt_pkg::S_ROOT_CUR: state_d = pxt_pkg::S_ROOT_PRE;
			pxt_pkg::S_ROOT_PRE: state_d = pxt_pkg::S_Q_A;
			pxt_pkg::S_Q_A: state_d = pxt_pkg::S_Q_B;
			pxt_pkg::S_Q_B: state_d = pxt_pkg::S_Q_C;
			pxt_pkg::S_Q_C: begin
				state_d = (lvl_q == LW'(1)) ? pxt_pkg::S_DONE : pxt_pkg::S_Q_B;
			end
			pxt_pkg::S_DONE: begin
				if (out_free) begin
					state_d = pxt_pkg::S_IDLE;
				end
			end
			default: state_d = pxt_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		rt_raddr = '0;
		rt_we    = 1'b0;
		rt_waddr = top_q + TW'(1);
		rt_wdata = free_q;
		nd_raddr = '0;
		nd_we    = 1'b0;
		nd_waddr = nn_q;
		nd_wdata = '0;
		case (state_q)
			pxt_pkg::S_DECODE: begin
				rt_raddr = (op_q == pxt_pkg::OP_PUSH) ? top_q : TW'(right_q);
			end
			pxt_pkg::S_ROOT_CUR: rt_raddr = TW'(left_q - pxt_pkg::POS_W'(1));
			pxt_pkg::S_PUSH_ROOT: nd_raddr = rt_rdata;
			pxt_pkg::S_PUSH_WR: begin
				nd_raddr = old_next;
				nd_we    = 1'b1;
				if (lvl_q == '0) begin
					rt_we    = 1'b1;
					nd_wdata = {NW'(0), NW'(0), CW'(0), CW'(0), od_cnt + CW'(1)};
				end else if (pbit) begin
					nd_wdata = {od_c0, nn_q + NW'(1), od_n0, od_n1 + CW'(1),
						od_cnt + CW'(1)};
				end else begin
					nd_wdata = {nn_q + NW'(1), od_c1, od_n0 + CW'(1), od_n1,
						od_cnt + CW'(1)};
				end
			end
			pxt_pkg::S_Q_A: nd_raddr = cur_q;
			pxt_pkg::S_Q_B: nd_raddr = pre_q;
			pxt_pkg::S_Q_C: nd_raddr = cur_next;
			default: nd_raddr = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= pxt_pkg::S_IDLE;
			top_q       <= '0;
			free_q      <= NW'(1);
			mask_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == pxt_pkg::S_DECODE) begin
				if (op_q == pxt_pkg::OP_POP && top_q != '0) begin
					top_q  <= top_q - TW'(1);
					free_q <= free_q - STEP;
				end
				if (op_q == pxt_pkg::OP_MASK) begin
					mask_q <= mask_q ^ keyv;
				end
			end
			if (state_q == pxt_pkg::S_PUSH_WR && lvl_q == '0) begin
				top_q  <= top_q + TW'(1);
				free_q <= free_q + STEP;
			end
			if (state_q == pxt_pkg::S_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q    <= operation;
			val_q   <= value;
			left_q  <= left;
			right_q <= right;
		end
		case (state_q)
			pxt_pkg::S_DECODE: begin
				key_q     <= (op_q == pxt_pkg::OP_COUNT || op_q == pxt_pkg::OP_KTH)
					? bound : (keyv ^ mask_q);
				msk_sh_q  <= mask_q;
				k_q       <= val_q;
				ans_q     <= '0;
				acc_q     <= '0;
				nn_q      <= free_q;
				lvl_q     <= LW'(KEY_BITS);
				res_ans_q <= '0;
				res_st_q  <= pxt_pkg::ST_OK;
				case (pxt_pkg::op_t'(op_q))
					pxt_pkg::OP_PUSH: begin
						if (top_q == TW'(MAX_DEPTH)) begin
							res_st_q <= pxt_pkg::ST_FULL;
						end
					end
					pxt_pkg::OP_POP: begin
						if (top_q == '0) begin
							res_st_q <= pxt_pkg::ST_EMPTY;
						end
					end
					pxt_pkg::OP_MAX, pxt_pkg::OP_COUNT: begin
						if (range_bad) begin
							res_st_q <= pxt_pkg::ST_RANGE;
						end
					end
					pxt_pkg::OP_KTH: begin
						if (range_bad || rank_bad) begin
							res_st_q <= pxt_pkg::ST_RANGE;
						end
					end
					default: res_st_q <= pxt_pkg::ST_OK;
				endcase
			end
			pxt_pkg::S_PUSH_WR: begin
				nn_q  <= nn_q + NW'(1);
				lvl_q <= lvl_q - LW'(1);
				key_q <= key_q << 1;
			end
			pxt_pkg::S_ROOT_CUR: cur_q <= rt_rdata;
			pxt_pkg::S_ROOT_PRE: pre_q <= rt_rdata;
			pxt_pkg::S_Q_B: curd_q <= nd_rdata;
			pxt_pkg::S_Q_C: begin
				cur_q    <= cur_next;
				pre_q    <= pre_next;
				key_q    <= key_q << 1;
				msk_sh_q <= msk_sh_q << 1;
				ans_q    <= ans_n;
				acc_q    <= acc_n;
				lvl_q    <= lvl_q - LW'(1);
				if (op_q == pxt_pkg::OP_KTH && take) begin
					k_q <= k_q - pxt_pkg::VALUE_W'(diff_m);
				end
				if (op_q == pxt_pkg::OP_COUNT) begin
					res_ans_q <= pxt_pkg::ANSWER_W'(acc_n);
				end else begin
					res_ans_q <= pxt_pkg::ANSWER_W'(ans_n);
				end
			end
			default: begin
			end
		endcase
		if (state_q == pxt_pkg::S_DONE && out_free) begin
			answer_q <= res_ans_q;
			status_q <= res_st_q;
		end
	end

	a_free_tracks_top: assert property (@(posedge clk) disable iff (!arst_n)
		free_q == NW'(1) + NW'(top_q) * STEP)
		else $error("free node pointer does not match the stack depth");

	a_top_bound: assert property (@(posedge clk) disable iff (!arst_n)
		top_q <= TW'(MAX_DEPTH))
		else $error("stack depth exceeds its capacity");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> in_stall)
		else $error("sequencer took an item without going busy");

	a_level_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == pxt_pkg::S_Q_C) |-> (lvl_q != '0))
		else $error("query walk ran past the last trie level");

endmodule

// File: rtl/pxt_ram.sv
// Synchronous memory with one write port, one registered read port and a zero sentinel entry.
module pxt_ram #(
	parameter int DEPTH = 2,
	parameter int AW    = 1,
	parameter int DW    = 1
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [0:DEPTH-1];
	logic [DW-1:0] rd_q;
	logic          zero_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rd_q   <= mem[raddr];
		zero_q <= (raddr == '0);
	end

	// Entry zero is the empty sentinel and is never written.
	assign rdata = zero_q ? '0 : rd_q;

endmodule
